// ===== hdl/emi_pkg.sv =====
// Shared types and constants for the epoch-milliseconds to ISO 8601 basic converter.
// Holds the result record and the reciprocal constants of every constant division.
// No dependencies.
package emi_pkg;

   // Number of register stages from the request transfer to the response register.
   localparam int unsigned STAGES = 18;

   // Day split: the low ten bits of the timestamp fall through, since 86400000 = 84375 * 1024.
   localparam logic [16:0] DAY_DIV        = 17'd84375;
   localparam logic [63:0] DAY_RECIP_FULL = ((64'd1 << 55) + 64'd84374) / 64'd84375;
   localparam logic [19:0] DAY_RECIP_LO   = DAY_RECIP_FULL[19:0];
   localparam logic [18:0] DAY_RECIP_HI   = DAY_RECIP_FULL[38:20];

   localparam logic [21:0] EPOCH_SHIFT = 22'd719468;

   // Seconds of day from (milliseconds of day >> 3) / 125.
   localparam logic [63:0] SOD_RECIP_FULL = ((64'd1 << 31) + 64'd124) / 64'd125;
   localparam logic [24:0] SOD_RECIP      = SOD_RECIP_FULL[24:0];

   localparam logic [17:0] ERA_DIV        = 18'd146097;
   localparam logic [17:0] ERA_LAST_DAY   = 18'd146096;
   localparam logic [63:0] ERA_RECIP_FULL = ((64'd1 << 40) + 64'd146096) / 64'd146097;
   localparam logic [22:0] ERA_RECIP      = ERA_RECIP_FULL[22:0];

   localparam logic [11:0] HOUR_SECS       = 12'd3600;
   localparam logic [63:0] HOUR_RECIP_FULL = ((64'd1 << 29) + 64'd3599) / 64'd3600;
   localparam logic [17:0] HOUR_RECIP      = HOUR_RECIP_FULL[17:0];

   localparam logic [5:0]  MIN_SECS       = 6'd60;
   localparam logic [63:0] MIN_RECIP_FULL = ((64'd1 << 18) + 64'd59) / 64'd60;
   localparam logic [12:0] MIN_RECIP      = MIN_RECIP_FULL[12:0];

   localparam logic [63:0] QUAD_RECIP_FULL = ((64'd1 << 29) + 64'd1459) / 64'd1460;
   localparam logic [18:0] QUAD_RECIP      = QUAD_RECIP_FULL[18:0];
   localparam logic [63:0] CENT_RECIP_FULL = ((64'd1 << 34) + 64'd36523) / 64'd36524;
   localparam logic [18:0] CENT_RECIP      = CENT_RECIP_FULL[18:0];

   localparam logic [8:0]  YEAR_DAYS       = 9'd365;
   localparam logic [63:0] YOE_RECIP_FULL  = ((64'd1 << 26) + 64'd364) / 64'd365;
   localparam logic [17:0] YOE_RECIP       = YOE_RECIP_FULL[17:0];
   // floor(yoe / 100) as (yoe * 41) >> 12, exact below 1024.
   localparam logic [5:0]  YOE_CENT_RECIP  = 6'd41;

   localparam logic [11:0] MP_RECIP   = 12'd3427;   // (5*doy+2)/153 as (v * 3427) >> 19
   localparam logic [7:0]  MP_DAYS    = 8'd153;
   localparam logic [11:0] FIFTH_RECIP = 12'd3277;  // w/5 as (w * 3277) >> 14
   localparam logic [8:0]  ERA_YEARS  = 9'd400;

   localparam logic [13:0] YEAR_WRAP     = 14'd10000;
   localparam logic [12:0] HUNDRED_RECIP = 13'd5243; // y/100 as (y * 5243) >> 19
   localparam logic [6:0]  HUNDRED       = 7'd100;
   localparam logic [7:0]  TENS_RECIP    = 8'd205;   // v/10 as (v * 205) >> 11
   localparam logic [3:0]  TEN           = 4'd10;

   localparam logic [3:0] DIGIT_HIGH_NIBBLE = 4'h3;
   localparam logic [7:0] CHAR_T            = 8'h54;
   localparam logic [7:0] CHAR_Z            = 8'h5A;

   typedef struct packed {
      logic        out_of_range;
      logic [63:0] text_low;
      logic [63:0] text_high;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } result_type;

endpackage

// ===== hdl/emi_datapath.sv =====
// Pipelined datapath of the converter: day split, civil-from-days and ASCII digits.
// Each stage loads when its bit of load is set; uses emi_pkg constants and result_type.
module emi_datapath (
   input  logic                         clock,
   input  logic [47:0]                  ts,
   input  logic [emi_pkg::STAGES-1:0]   load,
   output emi_pkg::result_type          result
);

   typedef struct packed {
      logic [37:0] x;
      logic [6:0]  frac;
      logic [38:0] pa;
      logic [37:0] pb;
   } s0_type;

   typedef struct packed {
      logic [37:0] x;
      logic [6:0]  frac;
      logic [76:0] acc;
      logic [38:0] pc;
      logic [37:0] pd;
   } s1_type;

   typedef struct packed {
      logic [37:0] x;
      logic [6:0]  frac;
      logic [21:0] days;
   } s2_type;

   typedef struct packed {
      logic [37:0] x;
      logic [6:0]  frac;
      logic [37:0] dprod;
      logic [21:0] z;
   } s3_type;

   typedef struct packed {
      logic [23:0] x2;
      logic [4:0]  era;
      logic [21:0] z;
   } s4_type;

   typedef struct packed {
      logic [16:0] sod;
      logic [17:0] doe;
      logic [4:0]  era;
   } s5_type;

   typedef struct packed {
      logic [16:0] sod;
      logic [4:0]  hour;
      logic [17:0] doe;
      logic [6:0]  qa;
      logic [2:0]  qb;
      logic        qc;
      logic [4:0]  era;
   } s6_type;

   typedef struct packed {
      logic [11:0] remh;
      logic [4:0]  hour;
      logic [17:0] doe;
      logic [17:0] t;
      logic [4:0]  era;
   } s7_type;

   typedef struct packed {
      logic [11:0] remh;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [17:0] doe;
      logic [8:0]  yoe;
      logic [4:0]  era;
   } s8_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [8:0] doy;
      logic [8:0] yoe;
      logic [4:0] era;
   } s9_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [8:0]  doy;
      logic [3:0]  mp;
      logic [13:0] ybase;
   } s10_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [8:0]  doy;
      logic [10:0] w;
      logic [3:0]  month;
      logic [13:0] ybase;
   } s11_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } s12_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [13:0] y4;
      logic        oor;
   } s13_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [13:0] y4;
      logic [6:0]  yc;
      logic        oor;
   } s14_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [6:0]  yc;
      logic [6:0]  yl;
      logic        oor;
   } s15_type;

   // Two-digit values, in text order: century, year of century, month, day,
   // hour, minute, second.
   typedef struct packed {
      logic [4:0]      hour;
      logic [5:0]      minute;
      logic [5:0]      second;
      logic [4:0]      day;
      logic [3:0]      month;
      logic [13:0]     year;
      logic            oor;
      logic [6:0][6:0] val;
      logic [6:0][3:0] tens;
   } s16_type;

   s0_type  s0_in,  s0_ff;
   s1_type  s1_in,  s1_ff;
   s2_type  s2_in,  s2_ff;
   s3_type  s3_in,  s3_ff;
   s4_type  s4_in,  s4_ff;
   s5_type  s5_in,  s5_ff;
   s6_type  s6_in,  s6_ff;
   s7_type  s7_in,  s7_ff;
   s8_type  s8_in,  s8_ff;
   s9_type  s9_in,  s9_ff;
   s10_type s10_in, s10_ff;
   s11_type s11_in, s11_ff;
   s12_type s12_in, s12_ff;
   s13_type s13_in, s13_ff;
   s14_type s14_in, s14_ff;
   s15_type s15_in, s15_ff;
   s16_type s16_in, s16_ff;
   emi_pkg::result_type s17_in, s17_ff;

   always_comb begin
      logic [76:0]     day_sum;
      logic [37:0]     rem_full;
      logic [44:0]     era_prod;
      logic [48:0]     sod_prod;
      logic [21:0]     doe_full;
      logic [34:0]     hour_prod;
      logic [36:0]     quad_prod;
      logic [36:0]     cent_prod;
      logic [16:0]     remh_full;
      logic [24:0]     min_prod;
      logic [35:0]     yoe_prod;
      logic [11:0]     sec_full;
      logic [14:0]     cent_yoe_prod;
      logic [17:0]     year_start;
      logic [17:0]     doy_full;
      logic [10:0]     mp_arg;
      logic [22:0]     mp_prod;
      logic [22:0]     fifth_prod;
      logic [26:0]     hundred_prod;
      logic [13:0]     yl_full;
      logic [14:0]     tens_prod;
      logic [6:0]      ones_full;
      logic [6:0][7:0] tens_char;
      logic [6:0][7:0] ones_char;

      // Stage 0: low half of the reciprocal product for the day count.
      s0_in.x    = ts[47:10];
      s0_in.frac = ts[9:3];
      s0_in.pa   = 39'(ts[28:10]) * 39'(emi_pkg::DAY_RECIP_LO);
      s0_in.pb   = 38'(ts[28:10]) * 38'(emi_pkg::DAY_RECIP_HI);

      // Stage 1: high half of the product, low partials summed.
      s1_in.x    = s0_ff.x;
      s1_in.frac = s0_ff.frac;
      s1_in.acc  = 77'(s0_ff.pa) + (77'(s0_ff.pb) << 20);
      s1_in.pc   = 39'(s0_ff.x[37:19]) * 39'(emi_pkg::DAY_RECIP_LO);
      s1_in.pd   = 38'(s0_ff.x[37:19]) * 38'(emi_pkg::DAY_RECIP_HI);

      // Stage 2: the reciprocal is 2^55/84375 rounded up, which keeps the quotient exact.
      day_sum     = s1_ff.acc + (77'(s1_ff.pc) << 19) + (77'(s1_ff.pd) << 39);
      s2_in.x     = s1_ff.x;
      s2_in.frac  = s1_ff.frac;
      s2_in.days  = day_sum[76:55];

      s3_in.x     = s2_ff.x;
      s3_in.frac  = s2_ff.frac;
      s3_in.dprod = 38'(s2_ff.days) * 38'(emi_pkg::DAY_DIV);
      s3_in.z     = s2_ff.days + emi_pkg::EPOCH_SHIFT;

      rem_full  = s3_ff.x - s3_ff.dprod;
      era_prod  = 45'(s3_ff.z) * 45'(emi_pkg::ERA_RECIP);
      s4_in.x2  = {rem_full[16:0], s3_ff.frac};
      s4_in.era = era_prod[44:40];
      s4_in.z   = s3_ff.z;

      sod_prod  = 49'(s4_ff.x2) * 49'(emi_pkg::SOD_RECIP);
      doe_full  = s4_ff.z - 22'(s4_ff.era) * 22'(emi_pkg::ERA_DIV);
      s5_in.sod = sod_prod[47:31];
      s5_in.doe = doe_full[17:0];
      s5_in.era = s4_ff.era;

      hour_prod  = 35'(s5_ff.sod) * 35'(emi_pkg::HOUR_RECIP);
      quad_prod  = 37'(s5_ff.doe) * 37'(emi_pkg::QUAD_RECIP);
      cent_prod  = 37'(s5_ff.doe) * 37'(emi_pkg::CENT_RECIP);
      s6_in.sod  = s5_ff.sod;
      s6_in.hour = hour_prod[33:29];
      s6_in.doe  = s5_ff.doe;
      s6_in.qa   = quad_prod[35:29];
      s6_in.qb   = cent_prod[36:34];
      s6_in.qc   = (s5_ff.doe == emi_pkg::ERA_LAST_DAY);
      s6_in.era  = s5_ff.era;

      remh_full  = s6_ff.sod - 17'(s6_ff.hour) * 17'(emi_pkg::HOUR_SECS);
      s7_in.remh = remh_full[11:0];
      s7_in.hour = s6_ff.hour;
      s7_in.doe  = s6_ff.doe;
      s7_in.t    = s6_ff.doe - 18'(s6_ff.qa) + 18'(s6_ff.qb) - 18'(s6_ff.qc);
      s7_in.era  = s6_ff.era;

      min_prod     = 25'(s7_ff.remh) * 25'(emi_pkg::MIN_RECIP);
      yoe_prod     = 36'(s7_ff.t) * 36'(emi_pkg::YOE_RECIP);
      s8_in.remh   = s7_ff.remh;
      s8_in.hour   = s7_ff.hour;
      s8_in.minute = min_prod[23:18];
      s8_in.doe    = s7_ff.doe;
      s8_in.yoe    = yoe_prod[34:26];
      s8_in.era    = s7_ff.era;

      sec_full      = s8_ff.remh - 12'(s8_ff.minute) * 12'(emi_pkg::MIN_SECS);
      cent_yoe_prod = 15'(s8_ff.yoe) * 15'(emi_pkg::YOE_CENT_RECIP);
      year_start    = 18'(s8_ff.yoe) * 18'(emi_pkg::YEAR_DAYS) + 18'(s8_ff.yoe[8:2])
                      - 18'(cent_yoe_prod[14:12]);
      doy_full      = s8_ff.doe - year_start;
      s9_in.hour    = s8_ff.hour;
      s9_in.minute  = s8_ff.minute;
      s9_in.second  = sec_full[5:0];
      s9_in.doy     = doy_full[8:0];
      s9_in.yoe     = s8_ff.yoe;
      s9_in.era     = s8_ff.era;

      // Month index counted from March.
      mp_arg        = {s9_ff.doy, 2'b00} + 11'(s9_ff.doy) + 11'd2;
      mp_prod       = 23'(mp_arg) * 23'(emi_pkg::MP_RECIP);
      s10_in.hour   = s9_ff.hour;
      s10_in.minute = s9_ff.minute;
      s10_in.second = s9_ff.second;
      s10_in.doy    = s9_ff.doy;
      s10_in.mp     = mp_prod[22:19];
      s10_in.ybase  = 14'(s9_ff.era) * 14'(emi_pkg::ERA_YEARS) + 14'(s9_ff.yoe);

      s11_in.hour   = s10_ff.hour;
      s11_in.minute = s10_ff.minute;
      s11_in.second = s10_ff.second;
      s11_in.doy    = s10_ff.doy;
      s11_in.w      = 11'(s10_ff.mp) * 11'(emi_pkg::MP_DAYS) + 11'd2;
      s11_in.month  = (s10_ff.mp < 4'd10) ? s10_ff.mp + 4'd3 : s10_ff.mp - 4'd9;
      s11_in.ybase  = s10_ff.ybase;

      // January and February belong to the next civil year.
      fifth_prod    = 23'(s11_ff.w) * 23'(emi_pkg::FIFTH_RECIP);
      s12_in.hour   = s11_ff.hour;
      s12_in.minute = s11_ff.minute;
      s12_in.second = s11_ff.second;
      s12_in.day    = 5'(s11_ff.doy - fifth_prod[22:14] + 9'd1);
      s12_in.month  = s11_ff.month;
      s12_in.year   = s11_ff.ybase + 14'(s11_ff.month <= 4'd2);

      s13_in.hour   = s12_ff.hour;
      s13_in.minute = s12_ff.minute;
      s13_in.second = s12_ff.second;
      s13_in.day    = s12_ff.day;
      s13_in.month  = s12_ff.month;
      s13_in.year   = s12_ff.year;
      s13_in.oor    = (s12_ff.year >= emi_pkg::YEAR_WRAP);
      s13_in.y4     = s13_in.oor ? s12_ff.year - emi_pkg::YEAR_WRAP : s12_ff.year;

      hundred_prod  = 27'(s13_ff.y4) * 27'(emi_pkg::HUNDRED_RECIP);
      s14_in.hour   = s13_ff.hour;
      s14_in.minute = s13_ff.minute;
      s14_in.second = s13_ff.second;
      s14_in.day    = s13_ff.day;
      s14_in.month  = s13_ff.month;
      s14_in.year   = s13_ff.year;
      s14_in.y4     = s13_ff.y4;
      s14_in.yc     = hundred_prod[25:19];
      s14_in.oor    = s13_ff.oor;

      yl_full       = s14_ff.y4 - 14'(s14_ff.yc) * 14'(emi_pkg::HUNDRED);
      s15_in.hour   = s14_ff.hour;
      s15_in.minute = s14_ff.minute;
      s15_in.second = s14_ff.second;
      s15_in.day    = s14_ff.day;
      s15_in.month  = s14_ff.month;
      s15_in.year   = s14_ff.year;
      s15_in.yc     = s14_ff.yc;
      s15_in.yl     = yl_full[6:0];
      s15_in.oor    = s14_ff.oor;

      s16_in.hour   = s15_ff.hour;
      s16_in.minute = s15_ff.minute;
      s16_in.second = s15_ff.second;
      s16_in.day    = s15_ff.day;
      s16_in.month  = s15_ff.month;
      s16_in.year   = s15_ff.year;
      s16_in.oor    = s15_ff.oor;
      s16_in.val[0] = s15_ff.yc;
      s16_in.val[1] = s15_ff.yl;
      s16_in.val[2] = 7'(s15_ff.month);
      s16_in.val[3] = 7'(s15_ff.day);
      s16_in.val[4] = 7'(s15_ff.hour);
      s16_in.val[5] = 7'(s15_ff.minute);
      s16_in.val[6] = 7'(s15_ff.second);
      for (int i = 0; i < 7; i++) begin
         tens_prod        = 15'(s16_in.val[i]) * 15'(emi_pkg::TENS_RECIP);
         s16_in.tens[i]   = tens_prod[14:11];
      end

      for (int i = 0; i < 7; i++) begin
         ones_full    = s16_ff.val[i] - 7'(s16_ff.tens[i]) * 7'(emi_pkg::TEN);
         tens_char[i] = {emi_pkg::DIGIT_HIGH_NIBBLE, s16_ff.tens[i]};
         ones_char[i] = {emi_pkg::DIGIT_HIGH_NIBBLE, ones_full[3:0]};
      end
      s17_in.year         = s16_ff.year;
      s17_in.month        = s16_ff.month;
      s17_in.day          = s16_ff.day;
      s17_in.hour         = s16_ff.hour;
      s17_in.minute       = s16_ff.minute;
      s17_in.second       = s16_ff.second;
      s17_in.out_of_range = s16_ff.oor;
      s17_in.text_high    = {tens_char[0], ones_char[0], tens_char[1], ones_char[1],
                             tens_char[2], ones_char[2], tens_char[3], ones_char[3]};
      s17_in.text_low     = {emi_pkg::CHAR_T, tens_char[4], ones_char[4],
                             tens_char[5], ones_char[5], tens_char[6], ones_char[6],
                             emi_pkg::CHAR_Z};
   end

   always_ff @(posedge clock) begin
      if (load[0])  s0_ff  <= s0_in;
      if (load[1])  s1_ff  <= s1_in;
      if (load[2])  s2_ff  <= s2_in;
      if (load[3])  s3_ff  <= s3_in;
      if (load[4])  s4_ff  <= s4_in;
      if (load[5])  s5_ff  <= s5_in;
      if (load[6])  s6_ff  <= s6_in;
      if (load[7])  s7_ff  <= s7_in;
      if (load[8])  s8_ff  <= s8_in;
      if (load[9])  s9_ff  <= s9_in;
      if (load[10]) s10_ff <= s10_in;
      if (load[11]) s11_ff <= s11_in;
      if (load[12]) s12_ff <= s12_in;
      if (load[13]) s13_ff <= s13_in;
      if (load[14]) s14_ff <= s14_in;
      if (load[15]) s15_ff <= s15_in;
      if (load[16]) s16_ff <= s16_in;
      if (load[17]) s17_ff <= s17_in;
   end

   assign result = s17_ff;

endmodule

// ===== hdl/epoch_ms_to_iso8601_basic_top.sv =====
// Epoch-milliseconds to civil UTC date, time and ISO 8601 basic text converter.
// Holds the stage valid bits and the stall logic; depends on emi_pkg and emi_datapath.
//
// Usage:
//   The req_ channel carries one Unix timestamp in milliseconds per transfer.
//   The rsp_ channel returns one result per request in the same order: the
//   year, month, day, hour, minute and second fields, the text YYYYMMDDTHHMMSSZ
//   as two 64-bit words (first character in the top byte) and an out-of-range
//   flag that is set when the year passes 9999 and the text year wraps.
//   rsp_tvalid rises once a request has passed the 18 register stages of the
//   datapath; the longest part is the day count, whose 38 by 39 bit reciprocal
//   product is built from partial products over three stages. Without a stall,
//   throughput is one transfer per cycle.
//   Each stage holds its item while the stage after it is full and stalled, so
//   empty stages keep filling while rsp_tready is low; req_tready falls only
//   once every stage holds an item. Nothing is lost or repeated under stalls.
//   A synchronous reset empties every stage; no other state is kept.
module epoch_ms_to_iso8601_basic_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // [47:0] epoch_msec
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
   // [39:34] second, [103:40] text_high, [167:104] text_low, [168] out_of_range,
   // [175:169] zero
   output logic [175:0] rsp_tdata
);

   localparam int unsigned LAST = emi_pkg::STAGES - 1;

   logic [emi_pkg::STAGES-1:0] valid_ff;
   logic [emi_pkg::STAGES-1:0] valid_in;
   logic [emi_pkg::STAGES-1:0] stage_ready;
   emi_pkg::result_type        result;

   // A stage may load when the response side takes data or some stage at or
   // after it is empty.
   for (genvar g = 0; g < emi_pkg::STAGES; g++) begin : g_ready
      assign stage_ready[g] = rsp_tready || !(&valid_ff[LAST:g]);
   end

   always_comb begin
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < emi_pkg::STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   emi_datapath u_datapath (
      .clock  (clock),
      .ts     (req_tdata),
      .load   (stage_ready),
      .result (result)
   );

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = {7'd0, result.out_of_range, result.text_low, result.text_high,
                        result.second, result.minute, result.hour, result.day,
                        result.month, result.year};

endmodule
